>>> hw/rtl/sssd_pkg.sv
// Shared types, constants and register codes for the stereo silence split detector.
package sssd_pkg;

  localparam int SSSD_MAX_BLOCK_LENGTH = 262144;
  localparam int SSSD_SAMPLE_BITS      = 24;

  localparam int BLOCK_LEN_W = 19;
  localparam int OFFSET_W    = 18;
  localparam int POS_W       = 32;
  localparam int THRESH_W    = 23;
  localparam int MIN_SIL_W   = 19;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [THRESH_W-1:0]  RST_SILENCE_THRESHOLD = 23'd83886;
  localparam logic [MIN_SIL_W-1:0] RST_MIN_SILENCE       = 19'd17640;
  localparam logic [POS_W-1:0]     RST_FIRST_WINDOW      = 32'd154129500;
  localparam logic [POS_W-1:0]     RST_LATER_WINDOW      = 32'd156775500;
  localparam logic [POS_W-1:0]     RST_WINDOW_LENGTH     = 32'd5292000;
  localparam logic [POS_W-1:0]     RST_END_GUARD         = 32'd2646000;
  localparam logic [POS_W-1:0]     RST_TOTAL_SAMPLES     = 32'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SILENCE_THRESHOLD = 3'd0,
    CFG_MIN_SILENCE       = 3'd1,
    CFG_FIRST_WINDOW      = 3'd2,
    CFG_LATER_WINDOW      = 3'd3,
    CFG_WINDOW_LENGTH     = 3'd4,
    CFG_END_GUARD         = 3'd5,
    CFG_TOTAL_SAMPLES     = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [THRESH_W-1:0]  silence_threshold;
    logic [MIN_SIL_W-1:0] min_silence_samples;
    logic [POS_W-1:0]     first_window_start;
    logic [POS_W-1:0]     later_window_start;
    logic [POS_W-1:0]     window_length;
    logic [POS_W-1:0]     end_guard_samples;
    logic [POS_W-1:0]     total_samples;
  } sssd_cfg_t;

endpackage

>>> hw/rtl/sssd_if.sv
// Valid/ready channel interfaces for sample pairs in and split results out.
interface sssd_in_if
  import sssd_pkg::*;
#(
  parameter int SAMPLE_BITS = SSSD_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic [BLOCK_LEN_W-1:0]        block_length;
  logic                          block_last;

  modport source (output valid, left_sample, right_sample, block_length, block_last,
                  input ready);
  modport sink   (input valid, left_sample, right_sample, block_length, block_last,
                  output ready);
endinterface

interface sssd_out_if
  import sssd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] boundary_offset;
  logic [POS_W-1:0]    boundary_position;

  modport source (output valid, boundary_offset, boundary_position, input ready);
  modport sink   (input valid, boundary_offset, boundary_position, output ready);
endinterface

>>> hw/rtl/sssd_cfg_regs.sv
// Configuration register file with plain write port.
module sssd_cfg_regs
  import sssd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output sssd_cfg_t              cfg
);

  sssd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.silence_threshold   <= RST_SILENCE_THRESHOLD;
      cfg_r.min_silence_samples <= RST_MIN_SILENCE;
      cfg_r.first_window_start  <= RST_FIRST_WINDOW;
      cfg_r.later_window_start  <= RST_LATER_WINDOW;
      cfg_r.window_length       <= RST_WINDOW_LENGTH;
      cfg_r.end_guard_samples   <= RST_END_GUARD;
      cfg_r.total_samples       <= RST_TOTAL_SAMPLES;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SILENCE_THRESHOLD: cfg_r.silence_threshold   <= cfg_wdata[THRESH_W-1:0];
        CFG_MIN_SILENCE:       cfg_r.min_silence_samples <= cfg_wdata[MIN_SIL_W-1:0];
        CFG_FIRST_WINDOW:      cfg_r.first_window_start  <= cfg_wdata[POS_W-1:0];
        CFG_LATER_WINDOW:      cfg_r.later_window_start  <= cfg_wdata[POS_W-1:0];
        CFG_WINDOW_LENGTH:     cfg_r.window_length       <= cfg_wdata[POS_W-1:0];
        CFG_END_GUARD:         cfg_r.end_guard_samples   <= cfg_wdata[POS_W-1:0];
        CFG_TOTAL_SAMPLES:     cfg_r.total_samples       <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/sssd_peak.sv
// Louder-channel magnitude of a stereo pair, most negative value saturated.
module sssd_peak
  import sssd_pkg::*;
#(
  parameter int SAMPLE_BITS = SSSD_SAMPLE_BITS
) (
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic [SAMPLE_BITS-2:0]        peak
);

  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] neg_l, neg_r;
  logic [SAMPLE_BITS-2:0] mag_l, mag_r;

  assign neg_l = (~left_sample) + 1'b1;
  assign neg_r = (~right_sample) + 1'b1;

  always_comb begin
    if (!left_sample[SAMPLE_BITS-1]) begin
      mag_l = left_sample[SAMPLE_BITS-2:0];
    end else if (left_sample == MOST_NEG) begin
      mag_l = '1;
    end else begin
      mag_l = neg_l[SAMPLE_BITS-2:0];
    end
    if (!right_sample[SAMPLE_BITS-1]) begin
      mag_r = right_sample[SAMPLE_BITS-2:0];
    end else if (right_sample == MOST_NEG) begin
      mag_r = '1;
    end else begin
      mag_r = neg_r[SAMPLE_BITS-2:0];
    end
  end

  assign peak = (mag_r > mag_l) ? mag_r : mag_l;

endmodule

>>> hw/rtl/sssd_tracker.sv
// Input register, position/silence tracking and result register.
module sssd_tracker
  import sssd_pkg::*;
#(
  parameter int MAX_BLOCK_LENGTH = SSSD_MAX_BLOCK_LENGTH,
  parameter int SAMPLE_BITS      = SSSD_SAMPLE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  sssd_cfg_t  cfg,
  sssd_in_if.sink    in_ch,
  sssd_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK_LENGTH);

  // input register
  logic                          in_valid_r;
  logic signed [SAMPLE_BITS-1:0] left_r, right_r;
  logic [BLOCK_LEN_W-1:0]        blen_r;
  logic                          last_r;

  // tracking state
  logic [POS_W-1:0] prog_pos_r, stream_pos_r;
  logic             first_program_r, in_silence_r, armed_r;
  logic [CNT_W-1:0] idx_r, sil_start_r;

  // result register
  logic                out_valid_r;
  logic [OFFSET_W-1:0] off_r;
  logic [POS_W-1:0]    pos_r;

  logic proc;
  logic [SAMPLE_BITS-2:0] peak;

  sssd_peak #(.SAMPLE_BITS(SAMPLE_BITS)) u_peak (
    .left_sample  (left_r),
    .right_sample (right_r),
    .peak         (peak)
  );

  assign proc        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || proc;

  // arming and run detection
  logic             block_start, arm_new, remain_ok, quiet, blk_end;
  logic [POS_W-1:0] ws;
  logic [POS_W:0]   we, pe;
  logic             armed_cur, sil_cur, sil_a, emit_a, emit_b, emit, armed_after;
  logic [CNT_W-1:0] start_cur, start_a, count, gap_a, gap_b, gap_sel, offset;
  logic [POS_W-1:0] off32, prog_base;

  always_comb begin
    block_start = (idx_r == '0);
    ws          = first_program_r ? cfg.first_window_start : cfg.later_window_start;
    we          = {1'b0, ws} + {1'b0, cfg.window_length};
    pe          = {1'b0, prog_pos_r} + (POS_W+1)'(blen_r);
    remain_ok   = (stream_pos_r < cfg.total_samples) &&
                  ((cfg.total_samples - stream_pos_r) > cfg.end_guard_samples);
    arm_new     = remain_ok && ({1'b0, prog_pos_r} < we) && ({1'b0, ws} < pe);

    armed_cur = block_start ? arm_new : armed_r;
    sil_cur   = block_start ? 1'b0 : in_silence_r;
    start_cur = block_start ? '0 : sil_start_r;

    quiet = 32'(peak) < 32'(cfg.silence_threshold);
    count = idx_r + 1'b1;
    blk_end = last_r || (count >= MAX_CNT);

    sil_a   = sil_cur;
    start_a = start_cur;
    emit_a  = 1'b0;
    gap_a   = idx_r - start_cur;
    if (armed_cur && quiet) begin
      if (!sil_cur) begin
        start_a = idx_r;
        sil_a   = 1'b1;
      end
    end else if (armed_cur && sil_cur) begin
      // run closed by a loud pair, which is not part of the gap
      sil_a  = 1'b0;
      emit_a = 32'(gap_a) >= 32'(cfg.min_silence_samples);
    end

    armed_after = armed_cur && !emit_a;
    // run still open at block end includes the last pair
    gap_b  = count - start_a;
    emit_b = blk_end && armed_after && sil_a &&
             (32'(gap_b) >= 32'(cfg.min_silence_samples));
    emit   = emit_a || emit_b;

    gap_sel   = emit_a ? gap_a : gap_b;
    offset    = start_a + (gap_sel >> 1);
    off32     = 32'(offset);
    prog_base = emit ? '0 : prog_pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      prog_pos_r      <= '0;
      stream_pos_r    <= '0;
      first_program_r <= 1'b1;
      in_silence_r    <= 1'b0;
      armed_r         <= 1'b0;
      idx_r           <= '0;
      sil_start_r     <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end

      if (proc) begin
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (proc) begin
        sil_start_r <= start_a;
        if (emit) begin
          first_program_r <= 1'b0;
        end
        if (blk_end) begin
          prog_pos_r   <= prog_base + 32'(count);
          stream_pos_r <= stream_pos_r + 32'(count);
          idx_r        <= '0;
          in_silence_r <= 1'b0;
          armed_r      <= 1'b0;
        end else begin
          prog_pos_r   <= prog_base;
          idx_r        <= count;
          in_silence_r <= sil_a;
          armed_r      <= armed_after;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      left_r  <= in_ch.left_sample;
      right_r <= in_ch.right_sample;
      blen_r  <= in_ch.block_length;
      last_r  <= in_ch.block_last;
    end
    if (proc && emit) begin
      off_r <= off32[OFFSET_W-1:0];
      pos_r <= stream_pos_r + off32;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.boundary_offset   = off_r;
  assign out_ch.boundary_position = pos_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(idx_r) < 32'(MAX_BLOCK_LENGTH))
    else $error("block index out of range");

  a_silence_armed: assert property (@(posedge clk) disable iff (!rst_n)
    in_silence_r |-> armed_r)
    else $error("silent run open in a disarmed block");

  a_start_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_silence_r |-> (sil_start_r <= idx_r))
    else $error("silent run starts after current index");

  a_split_effects: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit) |=> (out_valid_r && !first_program_r && !armed_r))
    else $error("split did not load result and disarm");

endmodule

>>> hw/rtl/stereo_silence_split_detector.sv
// Top level of the stereo silence split detector.
//
//   channel   dir  transfer rule           payload
//   in_ch     in   valid & ready at edge    left_sample, right_sample, block_length, block_last
//   out_ch    out  valid & ready at edge    boundary_offset, boundary_position
//   cfg_*     in   cfg_wr_en at edge        cfg_index, cfg_wdata (no read-back)
//
// One sample pair per cycle while no result is stalled; set by the single tracking stage.
// A pair passes through the input register, then the result register, before its result
// can transfer out.
// Reset (rst_n low, synchronous) clears positions, run state and registers to defaults.
// A stalled result holds the tracking stage; the input register still takes one pair.
module stereo_silence_split_detector
  import sssd_pkg::*;
#(
  parameter int MAX_BLOCK_LENGTH = SSSD_MAX_BLOCK_LENGTH,
  parameter int SAMPLE_BITS      = SSSD_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sssd_in_if.sink                in_ch,
  sssd_out_if.source             out_ch,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  sssd_cfg_t cfg;

  sssd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sssd_tracker #(
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
